// ===== src/rfc_pkg.sv =====
package rfc_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int NUM_TAPS   = 15;
	localparam int TAP_IDX_W  = 4;
	localparam int RAD_W      = 3;
	localparam int MAX_ROW    = 4096;
	localparam int COL_W      = 12;
	localparam int ZCNT_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_W      = 64;
	localparam int NUM_PACKS  = 4;
	localparam int TAPS_PER_PACK = 4;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int NUM_GRP    = 4;
	localparam int GRP_W      = PROD_W + 2;
	localparam int ACC_W      = PROD_W + 4;
	localparam int FRAC       = 15;
	localparam int Q_W        = ACC_W - FRAC;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = 2;
	localparam int QCNT_W     = 3;
	localparam int IDX_W      = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF1  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF2  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF3  = 3'd4;

	typedef logic [NUM_PACKS-1:0][CFG_W-1:0] rfc_coefs_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       row_end;
	} rfc_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic [COL_W-1:0]           column;
		logic                       clipped;
		logic                       row_done;
		logic                       last;
	} rfc_out_t;

	// classification of one word, travels alongside the mac pipeline
	typedef struct packed {
		logic              filt;
		logic              has_first;
		logic [COL_W-1:0]  first_col;
		logic [COL_W-1:0]  zero_start;
		logic [ZCNT_W-1:0] zero_cnt;
		logic              row_last;
		logic              nonempty;
	} rfc_ctl_t;

	// queue entry: everything the back end needs to emit a word's results
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       clipped;
		logic                       has_first;
		logic [COL_W-1:0]           first_col;
		logic [COL_W-1:0]           zero_start;
		logic [ZCNT_W-1:0]          zero_cnt;
		logic                       row_last;
	} rfc_cmd_t;

endpackage

// ===== src/rfc_front.sv =====
module rfc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rfc_pkg::rfc_in_t              in_word,
	input  logic [rfc_pkg::RAD_W-1:0]     radius,
	input  rfc_pkg::rfc_coefs_t           coefs,
	output logic                          push,
	output rfc_pkg::rfc_cmd_t             push_word,
	input  logic                          full
);
	import rfc_pkg::*;

	logic signed [SAMPLE_W-1:0] window_q [NUM_TAPS-1];
	logic signed [SAMPLE_W-1:0] win_next [NUM_TAPS];
	logic signed [COEF_W-1:0]   taps     [NUM_TAPS];
	logic [COL_W-1:0]           col_q;

	logic signed [PROD_W-1:0] prod_s1 [NUM_TAPS];
	logic signed [GRP_W-1:0]  grp_s2  [NUM_GRP];
	logic signed [ACC_W-1:0]  acc_s3;
	rfc_ctl_t                 ctl_c, ctl_s1, ctl_s2, ctl_s3;
	logic                     v_s1_q, v_s2_q, v_s3_q;
	logic                     en, accept;
	logic [NUM_TAPS-1:0]      lane_en;

	assign en       = !(v_s3_q && ctl_s3.nonempty && full);
	assign in_ready = en;
	assign accept   = in_valid && en;

	always_comb begin
		win_next[0] = in_word.sample;
		for (int d = 1; d < NUM_TAPS; d++) begin
			win_next[d] = window_q[d-1];
		end
		for (int d = 0; d < NUM_TAPS; d++) begin
			taps[d]    = coefs[d / TAPS_PER_PACK][COEF_W*(d % TAPS_PER_PACK) +: COEF_W];
			lane_en[d] = TAP_IDX_W'(d) <= {radius, 1'b0};
		end
	end

	// classify the incoming word
	always_comb begin
		logic [COL_W-1:0] r_ext;
		r_ext              = COL_W'(radius);
		ctl_c.has_first    = col_q >= r_ext;
		ctl_c.first_col    = col_q - r_ext;
		ctl_c.filt         = col_q >= COL_W'({radius, 1'b0});
		ctl_c.row_last     = in_word.row_end || (col_q == COL_W'(MAX_ROW - 1));
		if (!ctl_c.row_last) begin
			ctl_c.zero_cnt   = '0;
			ctl_c.zero_start = '0;
		end else if (ctl_c.has_first) begin
			ctl_c.zero_cnt   = radius;
			ctl_c.zero_start = col_q + COL_W'(1) - r_ext;
		end else begin
			ctl_c.zero_cnt   = col_q[ZCNT_W-1:0] + ZCNT_W'(1);
			ctl_c.zero_start = '0;
		end
		ctl_c.nonempty = ctl_c.has_first || (ctl_c.zero_cnt != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			for (int d = 0; d < NUM_TAPS - 1; d++) begin
				window_q[d] <= '0;
			end
		end else if (accept) begin
			col_q <= ctl_c.row_last ? '0 : col_q + COL_W'(1);
			for (int d = 0; d < NUM_TAPS - 1; d++) begin
				window_q[d] <= win_next[d];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
		end else if (en) begin
			v_s1_q <= accept;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
		end
	end

	// one multiplier per lane, unused taps masked
	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < NUM_TAPS; d++) begin
				prod_s1[d] <= lane_en[d] ? PROD_W'(win_next[d] * taps[d]) : '0;
			end
			ctl_s1 <= ctl_c;
		end
	end

	// registered adder tree: groups of four, then the total
	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < NUM_GRP; g++) begin
				logic signed [GRP_W-1:0] s;
				s = '0;
				for (int j = 0; j < TAPS_PER_PACK; j++) begin
					if (g * TAPS_PER_PACK + j < NUM_TAPS) begin
						s = s + GRP_W'(prod_s1[g*TAPS_PER_PACK + j]);
					end
				end
				grp_s2[g] <= s;
			end
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [ACC_W-1:0] t;
			t = '0;
			for (int g = 0; g < NUM_GRP; g++) begin
				t = t + ACC_W'(grp_s2[g]);
			end
			acc_s3 <= t;
			ctl_s3 <= ctl_s2;
		end
	end

	// round half up, floor shift, saturate
	always_comb begin
		logic signed [ACC_W-1:0] rnd;
		logic [Q_W-1:0]          q;
		logic [Q_W-SAMPLE_W:0]   top;
		logic                    ovf;
		rnd = acc_s3 + ACC_W'(1 << (FRAC - 1));
		q   = rnd[ACC_W-1:FRAC];
		top = q[Q_W-1:SAMPLE_W-1];
		ovf = !((&top) || !(|top));
		push_word.clipped = ctl_s3.filt && ovf;
		if (!ctl_s3.filt) begin
			push_word.value = '0;
		end else if (ovf) begin
			push_word.value = q[Q_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
			                           : {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else begin
			push_word.value = q[SAMPLE_W-1:0];
		end
		push_word.has_first  = ctl_s3.has_first;
		push_word.first_col  = ctl_s3.first_col;
		push_word.zero_start = ctl_s3.zero_start;
		push_word.zero_cnt   = ctl_s3.zero_cnt;
		push_word.row_last   = ctl_s3.row_last;
	end

	assign push = v_s3_q && ctl_s3.nonempty && !full;

`ifndef SYNTHESIS
	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_word.row_end |=> col_q == '0)
		else $error("column count not cleared after row end");
`endif

endmodule

// ===== src/rfc_queue.sv =====
module rfc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rfc_pkg::rfc_cmd_t push_word,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output rfc_pkg::rfc_cmd_t head_word
);
	import rfc_pkg::*;

	rfc_cmd_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = count_q == QCNT_W'(QDEPTH);
	assign head_valid = count_q != '0;
	assign head_word  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + QCNT_W'(1))
		else $error("queue fill count out of step");
`endif

endmodule

// ===== src/rfc_back.sv =====
module rfc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  rfc_pkg::rfc_cmd_t head_word,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output rfc_pkg::rfc_out_t out_word
);
	import rfc_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic [IDX_W:0]   total;
	logic             load, final_one;
	logic             out_valid_q;
	rfc_out_t         out_q, nxt;

	assign total     = (IDX_W+1)'(head_word.has_first) + (IDX_W+1)'(head_word.zero_cnt);
	assign final_one = {1'b0, idx_q} == total - (IDX_W+1)'(1);
	assign load      = head_valid && (!out_valid_q || out_ready);
	assign pop       = load && final_one;

	always_comb begin
		logic [IDX_W-1:0] zi;
		zi = idx_q - IDX_W'(head_word.has_first);
		if (head_word.has_first && idx_q == '0) begin
			nxt.value   = head_word.value;
			nxt.column  = head_word.first_col;
			nxt.clipped = head_word.clipped;
		end else begin
			nxt.value   = '0;
			nxt.column  = head_word.zero_start + COL_W'(zi);
			nxt.clipped = 1'b0;
		end
		nxt.last     = final_one;
		nxt.row_done = final_one && head_word.row_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= final_one ? '0 : idx_q + IDX_W'(1);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

`ifndef SYNTHESIS
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.row_done |-> out_word.last)
		else $error("row done without last flag");
`endif

endmodule

// ===== src/row_fir_convolver_zero_border.sv =====
// an accepted word passes product, group-sum, total, queue and output registers
// one word per cycle until the queue fills; row ends give up to radius + 1 results
// the expander sets the output rate: one result per cycle while out_ready is high
// reset: arst_n clears window, column count, pipeline valids, queue and registers
// no clearing pass after reset; the block takes words in the first cycle after release
module row_fir_convolver_zero_border (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  rfc_pkg::rfc_in_t                in_word,
	output logic                            out_valid,
	input  logic                            out_ready,
	output rfc_pkg::rfc_out_t               out_word,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rfc_pkg::CFG_W-1:0]       cfg_data
);
	import rfc_pkg::*;

	// configuration registers
	logic [RAD_W-1:0] radius_q;
	rfc_coefs_t       coefs_q;

	// front to queue
	logic     push, full;
	rfc_cmd_t push_word;

	// queue to back
	logic     pop, head_valid;
	rfc_cmd_t head_word;

	// config writes are always taken; unknown indexes drop the word
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			coefs_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RADIUS: radius_q   <= cfg_data[RAD_W-1:0];
				CFG_COEF0:  coefs_q[0] <= cfg_data;
				CFG_COEF1:  coefs_q[1] <= cfg_data;
				CFG_COEF2:  coefs_q[2] <= cfg_data;
				CFG_COEF3:  coefs_q[3] <= cfg_data;
				default:    radius_q   <= radius_q;
			endcase
		end
	end

	// front: sample window, classification, mac pipeline, rounding
	rfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.radius    (radius_q),
		.coefs     (coefs_q),
		.push      (push),
		.push_word (push_word),
		.full      (full)
	);

	// short queue so the front keeps going while the back drains border zeros
	rfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_word  (push_word),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_word  (head_word)
	);

	// back: expands each queue entry into its result words
	rfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_word  (head_word),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word)
	);

endmodule

// ===== test/row_fir_convolver_zero_border_tb.sv =====
module row_fir_convolver_zero_border_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rfc_pkg::*;

	// quiet cycles before the run is declared hung; well above the long receiver hold
	localparam int WATCHDOG_LIMIT = 2000;
	// covers words still in the multiplier, group-sum and total stages that give no result
	localparam int SETTLE_CYCLES  = 10;
	// long receiver hold, so that the result queue fills and in_ready drops
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_AT_WORD   = 150;
	localparam int MAX_STEP       = 2 ** RAD_W;
	localparam longint SAT_HI     = 2 ** (SAMPLE_W - 1) - 1;
	localparam longint SAT_LO     = -(2 ** (SAMPLE_W - 1));

	// how a kernel's taps are drawn
	typedef enum int {TAPS_RANDOM, TAPS_EXTREME, TAPS_SMOOTH} tap_style_t;

	// row convolution predictor and the results it still expects
	class conv_scoreboard;
		logic [RAD_W-1:0]           radius;
		logic [CFG_W-1:0]           coef [NUM_PACKS];
		logic signed [SAMPLE_W-1:0] window [NUM_TAPS];
		int unsigned                col_next;
		rfc_out_t                   step [MAX_STEP];
		int unsigned                cnt;
		rfc_out_t                   expected_px [$];
		int unsigned                errors, words, results, rows, clips;

		function new();
			radius = '0;
			foreach (coef[p]) coef[p] = '0;
			foreach (window[d]) window[d] = '0;
			col_next = 0;
			errors = 0;
			words = 0;
			results = 0;
			rows = 0;
			clips = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_RADIUS: radius = data[RAD_W-1:0];
				CFG_COEF0:  coef[0] = data;
				CFG_COEF1:  coef[1] = data;
				CFG_COEF2:  coef[2] = data;
				CFG_COEF3:  coef[3] = data;
				default: ;
			endcase
		endfunction

		function logic signed [COEF_W-1:0] tap(int unsigned t);
			return coef[t / TAPS_PER_PACK][(t % TAPS_PER_PACK) * COEF_W +: COEF_W];
		endfunction

		function void push(logic signed [SAMPLE_W-1:0] v, int unsigned col, logic clip);
			step[cnt].value    = v;
			step[cnt].column   = col[COL_W-1:0];
			step[cnt].clipped  = clip;
			step[cnt].row_done = 1'b0;
			step[cnt].last     = 1'b0;
			cnt++;
		endfunction

		function void take_word(rfc_in_t w);
			int unsigned r, n, c, d, i;
			longint acc, q;
			logic signed [SAMPLE_W-1:0] v;
			logic clip;
			r = radius;
			n = col_next;
			cnt = 0;
			words++;
			for (d = NUM_TAPS - 1; d > 0; d--) window[d] = window[d-1];
			window[0] = w.sample;
			// interior or leading border column, due once sample c+r is in
			if (n >= r) begin
				v = '0;
				clip = 1'b0;
				if (n >= 2 * r) begin
					acc = 0;
					for (d = 0; d <= 2 * r; d++) acc += longint'(window[d]) * longint'(tap(d));
					q = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
					if (q > SAT_HI) begin
						q = SAT_HI;
						clip = 1'b1;
					end else if (q < SAT_LO) begin
						q = SAT_LO;
						clip = 1'b1;
					end
					v = q[SAMPLE_W-1:0];
				end
				push(v, n - r, clip);
			end
			// row end, flagged or forced by the width limit: trailing border zeros
			if (w.row_end || n >= MAX_ROW - 1) begin
				for (c = (n + 1 > r) ? n + 1 - r : 0; c <= n; c++) push('0, c, 1'b0);
				step[cnt-1].row_done = 1'b1;
				rows++;
				col_next = 0;
			end else begin
				col_next = n + 1;
			end
			if (cnt > 0) step[cnt-1].last = 1'b1;
			for (i = 0; i < cnt; i++) expected_px.push_back(step[i]);
		endfunction

		function void check_result(rfc_out_t got);
			rfc_out_t e;
			results++;
			if (expected_px.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual value %0d column %0d",
					$time, got.value, got.column);
				return;
			end
			e = expected_px.pop_front();
			if (e.clipped) clips++;
			if (got.value !== e.value) begin
				errors++;
				$display("%0t: column %0d value expected %0d actual %0d",
					$time, e.column, e.value, got.value);
			end
			if (got.column !== e.column) begin
				errors++;
				$display("%0t: column expected %0d actual %0d", $time, e.column, got.column);
			end
			if (got.clipped !== e.clipped) begin
				errors++;
				$display("%0t: column %0d clipped expected %b actual %b",
					$time, e.column, e.clipped, got.clipped);
			end
			if (got.row_done !== e.row_done) begin
				errors++;
				$display("%0t: column %0d row_done expected %b actual %b",
					$time, e.column, e.row_done, got.row_done);
			end
			if (got.last !== e.last) begin
				errors++;
				$display("%0t: column %0d last expected %b actual %b",
					$time, e.column, e.last, got.last);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	rfc_in_t               in_word;
	logic                  out_valid;
	logic                  out_ready;
	rfc_out_t              out_word;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	conv_scoreboard sb = new();
	int unsigned    send_burst = 0;
	int unsigned    recv_burst = 0;
	bit             hold_done = 1'b0;

	row_fir_convolver_zero_border i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// idle cycles before the next word: usually random, with bursts of back-to-back words
	function automatic int unsigned draw_gap(inout int unsigned burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 6);
	endfunction

	// extremes often, otherwise the full 16-bit range
	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return '0;
			3: return '1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// offer one word and hold it until taken; valid stays high for the next word if no gap
	task automatic send_word(logic signed [SAMPLE_W-1:0] s, logic e);
		int unsigned gap;
		gap = draw_gap(send_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= '{sample: s, row_end: e};
		do @(posedge clk); while (!in_ready);
		sb.take_word(in_word);
	endtask

	task automatic send_row(int unsigned width);
		int unsigned i;
		for (i = 0; i < width; i++) send_word(rand_sample(), i == width - 1);
	endtask

	// one register write; the caller lowers cfg_valid after its last write
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	// stop sending, wait for every expected result, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_px.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// full kernel load: radius with random upper data bits, all four tap packs,
	// and now and then a write to an unused index that must change nothing
	task automatic set_kernel(int unsigned r, tap_style_t style);
		logic [CFG_W-1:0]     packs [NUM_PACKS];
		logic [CFG_W-1:0]     rdata;
		logic [COEF_W-1:0]    c;
		logic [CFG_IDX_W-1:0] spare;
		int unsigned          p, t;
		for (p = 0; p < NUM_PACKS; p++) packs[p] = {$urandom, $urandom};
		if (style != TAPS_RANDOM) begin
			for (t = 0; t < NUM_TAPS; t++) begin
				if (style == TAPS_EXTREME) begin
					case ($urandom_range(0, 3))
						0: c = 16'h7fff;
						1: c = 16'h8000;
						2: c = '0;
						default: c = '1;
					endcase
				end else begin
					// roughly unity gain, occasionally a touch above
					c = COEF_W'($urandom_range(0, 40000 / (2 * r + 1)));
				end
				packs[t / TAPS_PER_PACK][(t % TAPS_PER_PACK) * COEF_W +: COEF_W] = c;
			end
		end
		rdata = {$urandom, $urandom};
		rdata[RAD_W-1:0] = r[RAD_W-1:0];
		cfg_write(CFG_RADIUS, rdata);
		for (p = 0; p < NUM_PACKS; p++) cfg_write(CFG_IDX_W'(CFG_COEF0 + p), packs[p]);
		if ($urandom_range(0, 1) == 0) begin
			spare = CFG_IDX_W'(CFG_COEF3 + $urandom_range(1, 3));
			cfg_write(spare, {$urandom, $urandom});
		end
		cfg_valid <= 1'b0;
	endtask

	// receiver: random stalls, plus one long hold once the random part is under way
	initial begin : receiver
		int unsigned gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap(recv_burst);
			if (!hold_done && sb.words >= HOLD_AT_WORD) begin
				hold_done = 1'b1;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_result(out_word);
		end
	end

	// hang detection: any handshake on any channel resets the count
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("row_fir_convolver_zero_border test failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned ph, r, sent, width, i;
		int          k;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_word   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset kernel: radius 0, all taps zero, so every column reads zero
		send_word(16'sh7fff, 1'b0);
		send_word(16'sh8000, 1'b1);
		settle();

		// radius 1 with full-scale taps: saturation both ways, a short row,
		// and a row that ends on its first word
		cfg_write(CFG_RADIUS, 64'd1);
		cfg_write(CFG_COEF0, {16'h8000, 16'h7fff, 16'h7fff, 16'h7fff});
		for (k = 1; k < NUM_PACKS; k++)
			cfg_write(CFG_IDX_W'(CFG_COEF0 + k), {$urandom, $urandom});
		// unused indexes are ignored
		for (k = CFG_COEF3 + 1; k < 2 ** CFG_IDX_W; k++) cfg_write(CFG_IDX_W'(k), '1);
		cfg_valid <= 1'b0;
		for (i = 0; i < 6; i++) send_word(i < 3 ? 16'sh7fff : 16'sh8000, i == 5);
		send_word(16'sd100, 1'b0);
		send_word(-16'sd5, 1'b1);
		send_word(16'sd7, 1'b1);
		settle();

		// radius changed in the middle of a row, with the block idle
		cfg_write(CFG_RADIUS, 64'd2);
		cfg_valid <= 1'b0;
		for (i = 0; i < 3; i++) send_word(rand_sample(), 1'b0);
		settle();
		cfg_write(CFG_RADIUS, 64'd5);
		cfg_valid <= 1'b0;
		for (i = 0; i < 4; i++) send_word(rand_sample(), i == 3);

		// random rows over several kernels, widest and narrowest radius first
		for (ph = 0; ph < 8; ph++) begin
			r = (ph == 0) ? 7 : (ph == 1) ? 0 : $urandom_range(0, 7);
			settle();
			set_kernel(r, tap_style_t'(ph % 3));
			sent = 0;
			while (sent < 20) begin
				if ($urandom_range(0, 4) == 0)
					width = $urandom_range(1, 2 * r + 1);
				else
					width = $urandom_range(2 * r + 1, 2 * r + 24);
				send_row(width);
				sent += width;
			end
		end

		settle();
		$display("covered %0d words and %0d results over %0d rows, radius 0 to 7, %0d saturated",
			sb.words, sb.results, sb.rows, sb.clips);
		$display("kernels random, full-scale and smoothing; short rows and border-only rows");
		if (sb.errors == 0 && sb.expected_px.size() == 0) begin
			$display("row_fir_convolver_zero_border test passed");
		end else begin
			$display("row_fir_convolver_zero_border test failed");
		end
		$finish;
	end

endmodule
